/* hw/rtl/rmc_pkg.sv */
// ----------------------------------------------------------------------------
// rmc_pkg
// Shared constants, codes and controller/datapath handshake types for the
// region mean colour change detector.
// ----------------------------------------------------------------------------
package rmc_pkg;

	// default pixel bound per region frame
	localparam int unsigned DEF_MAX_PIXELS = 4096;

	// channel and threshold widths
	localparam int unsigned CH_W   = 8;
	localparam int unsigned THR_W  = 10;
	localparam int unsigned DIFF_W = 10;

	// restoring divider: one quotient bit per step
	localparam int unsigned DIV_STEPS = CH_W;
	localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

	// configuration port
	localparam int unsigned APB_AW = 2;
	localparam int unsigned APB_DW = 32;
	localparam logic [APB_AW-1:0] ADDR_THRESH = 2'd0;
	localparam logic [THR_W-1:0]  THRESH_RST  = 10'd3;

	// controller commands to the datapath
	typedef struct packed {
		logic accum;    // add a non-final pixel
		logic load;     // add the final pixel, load divider, clear sums
		logic div_step; // one restoring division step on all channels
		logic commit;   // decide emit, update last colour / output word
	} rmc_cmd_t;

	// datapath status to the controller
	typedef struct packed {
		logic emit;      // new mean differs enough to be sent, or none sent yet
		logic out_stall; // output word still held, not taken this cycle
	} rmc_sts_t;

endpackage

/* hw/rtl/rmc_if.sv */
// ----------------------------------------------------------------------------
// rmc_if
// Valid/ready channels: pixel words in, mean colour words out.
// ----------------------------------------------------------------------------
interface rmc_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_red;
	logic [7:0] pixel_green;
	logic [7:0] pixel_blue;
	logic       last_pixel;

	modport source (output valid, pixel_red, pixel_green, pixel_blue, last_pixel,
		input ready);
	modport sink (input valid, pixel_red, pixel_green, pixel_blue, last_pixel,
		output ready);
endinterface

interface rmc_mean_if;
	logic       valid;
	logic       ready;
	logic [7:0] mean_red;
	logic [7:0] mean_green;
	logic [7:0] mean_blue;

	modport source (output valid, mean_red, mean_green, mean_blue, input ready);
	modport sink (input valid, mean_red, mean_green, mean_blue, output ready);
endinterface

/* hw/rtl/rmc_ctrl.sv */
// ----------------------------------------------------------------------------
// rmc_ctrl
// Sequencer: accumulate pixels, run the 8-step divide at the frame end,
// then make the emit decision once the output word is free or nothing is sent.
// ----------------------------------------------------------------------------
module rmc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_last,
	output logic            in_ready,
	input  rmc_pkg::rmc_sts_t sts,
	output rmc_pkg::rmc_cmd_t cmd
);
	import rmc_pkg::*;

	typedef enum logic [2:0] {
		ST_ACCUM  = 3'b001,
		ST_DIV    = 3'b010,
		ST_DECIDE = 3'b100
	} state_t;

	state_t            state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic              accept;

	assign in_ready = (state_q == ST_ACCUM);
	assign accept   = in_valid && in_ready;

	// commands
	always_comb begin
		cmd.accum    = accept && !in_last;
		cmd.load     = accept && in_last;
		cmd.div_step = (state_q == ST_DIV);
		cmd.commit   = (state_q == ST_DECIDE) && !(sts.emit && sts.out_stall);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_ACCUM: begin
				if (cmd.load) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (step_q == STEP_W'(DIV_STEPS - 1)) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (cmd.commit) state_d = ST_ACCUM;
			end
			default: state_d = ST_ACCUM;
		endcase
	end

	// state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCUM;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load)          step_q <= '0;
			else if (cmd.div_step) step_q <= step_q + STEP_W'(1);
		end
	end

endmodule

/* hw/rtl/rmc_dp.sv */
// ----------------------------------------------------------------------------
// rmc_dp
// Datapath: channel sums and pixel count, three restoring dividers sharing
// one shifted divisor, last-colour store, change test and output register.
// ----------------------------------------------------------------------------
module rmc_dp #(
	parameter int unsigned MAX_PIXELS = rmc_pkg::DEF_MAX_PIXELS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  rmc_pkg::rmc_cmd_t        cmd,
	output rmc_pkg::rmc_sts_t        sts,
	input  logic [7:0]               pixel_red,
	input  logic [7:0]               pixel_green,
	input  logic [7:0]               pixel_blue,
	input  logic [rmc_pkg::THR_W-1:0] thresh,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [7:0]               mean_red,
	output logic [7:0]               mean_green,
	output logic [7:0]               mean_blue
);
	import rmc_pkg::*;

	localparam int unsigned TW = $clog2(MAX_PIXELS + 1); // tally width
	localparam int unsigned SW = TW + CH_W;              // sum / remainder width
	localparam int unsigned DW = TW + DIV_STEPS - 1;     // shifted divisor width

	logic [SW-1:0]   sum_q [3];
	logic [SW-1:0]   sum_nx [3];
	logic [TW-1:0]   tally_q, tally_nx;
	logic            room;
	logic [CH_W-1:0] pix [3];

	logic [SW-1:0]   rem_q [3];
	logic [SW-1:0]   rem_nx [3];
	logic [CH_W-1:0] quo_q [3];
	logic [2:0]      qbit;
	logic [DW-1:0]   dsh_q;

	logic [CH_W-1:0] prev_q [3];
	logic            prev_valid_q;
	logic [CH_W-1:0] mean_q [3];
	logic            out_valid_q;

	logic [CH_W-1:0] adiff [3];
	logic [DIFF_W-1:0] diff;

	assign pix[0] = pixel_red;
	assign pix[1] = pixel_green;
	assign pix[2] = pixel_blue;

	// accumulate while the count is below the bound
	assign room     = (tally_q < TW'(MAX_PIXELS));
	assign tally_nx = room ? tally_q + TW'(1) : tally_q;
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum_nx[c] = room ? sum_q[c] + SW'(pix[c]) : sum_q[c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tally_q <= '0;
			for (int c = 0; c < 3; c++) sum_q[c] <= '0;
		end else if (cmd.load) begin
			tally_q <= '0;
			for (int c = 0; c < 3; c++) sum_q[c] <= '0;
		end else if (cmd.accum) begin
			tally_q <= tally_nx;
			for (int c = 0; c < 3; c++) sum_q[c] <= sum_nx[c];
		end
	end

	// divide step: compare remainder against count shifted to this bit
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			qbit[c]   = (rem_q[c] >= SW'(dsh_q));
			rem_nx[c] = qbit[c] ? rem_q[c] - SW'(dsh_q) : rem_q[c];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dsh_q <= {tally_nx, (DIV_STEPS - 1)'(0)};
			for (int c = 0; c < 3; c++) rem_q[c] <= sum_nx[c];
		end else if (cmd.div_step) begin
			dsh_q <= dsh_q >> 1;
			for (int c = 0; c < 3; c++) begin
				rem_q[c] <= rem_nx[c];
				quo_q[c] <= {quo_q[c][CH_W-2:0], qbit[c]};
			end
		end
	end

	// summed absolute difference from last sent colour
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			adiff[c] = (quo_q[c] > prev_q[c]) ? quo_q[c] - prev_q[c] : prev_q[c] - quo_q[c];
		end
		diff = DIFF_W'(adiff[0]) + DIFF_W'(adiff[1]) + DIFF_W'(adiff[2]);
	end

	assign sts.emit      = !prev_valid_q || (diff > thresh);
	assign sts.out_stall = out_valid_q && !out_ready;

	// last colour and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int c = 0; c < 3; c++) prev_q[c] <= '0;
		end else begin
			if (cmd.commit && sts.emit) begin
				prev_valid_q <= 1'b1;
				out_valid_q  <= 1'b1;
				for (int c = 0; c < 3; c++) prev_q[c] <= quo_q[c];
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && sts.emit) begin
			for (int c = 0; c < 3; c++) mean_q[c] <= quo_q[c];
		end
	end

	assign out_valid  = out_valid_q;
	assign mean_red   = mean_q[0];
	assign mean_green = mean_q[1];
	assign mean_blue  = mean_q[2];

endmodule

/* hw/rtl/region_mean_colour_change_detect.sv */
// ----------------------------------------------------------------------------
// region_mean_colour_change_detect
// Region mean colour with change threshold; APB threshold register.
// ----------------------------------------------------------------------------
// Pixels are taken one per cycle while the input is open; after the final
// pixel, ready stays low through the 8 divider steps (one quotient bit per
// cycle) and the decide state, longer if the output word is held.
// A sent mean shows on the output the cycle after the decide cycle.
// Reset clears sums, count and last colour; the threshold resets to 3.
// ----------------------------------------------------------------------------
module region_mean_colour_change_detect #(
	parameter int unsigned MAX_PIXELS = rmc_pkg::DEF_MAX_PIXELS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	rmc_pix_if.sink                     pix,
	rmc_mean_if.source                  mean,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [rmc_pkg::APB_AW-1:0]  paddr,
	input  logic [rmc_pkg::APB_DW-1:0]  pwdata,
	output logic [rmc_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);
	import rmc_pkg::*;

	logic [THR_W-1:0] thresh_q;
	logic             cfg_wr;
	rmc_cmd_t         cmd;
	rmc_sts_t         sts;
	logic             in_ready;

	// threshold register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RST;
		end else if (cfg_wr && (paddr == ADDR_THRESH)) begin
			thresh_q <= pwdata[THR_W-1:0];
		end
	end

	assign prdata = (paddr == ADDR_THRESH) ? APB_DW'(thresh_q) : '0;

	assign pix.ready = in_ready;

	rmc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pix.valid),
		.in_last  (pix.last_pixel),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rmc_dp #(
		.MAX_PIXELS (MAX_PIXELS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.pixel_red   (pix.pixel_red),
		.pixel_green (pix.pixel_green),
		.pixel_blue  (pix.pixel_blue),
		.thresh      (thresh_q),
		.out_valid   (mean.valid),
		.out_ready   (mean.ready),
		.mean_red    (mean.mean_red),
		.mean_green  (mean.mean_green),
		.mean_blue   (mean.mean_blue)
	);

	// final pixel starts the divide, so input closes next cycle
	a_last_closes_input: assert property (@(posedge clk) disable iff (!arst_n)
		(pix.valid && in_ready && pix.last_pixel) |=> !in_ready)
		else $error("input still open after final pixel");

	// a new mean only appears out of the divide/decide phase
	a_mean_after_divide: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(mean.valid) |-> $past(!in_ready))
		else $error("mean word raised outside decide");

	// only a register write changes the threshold
	a_thresh_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_wr |=> $stable(thresh_q))
		else $error("threshold changed without write");

	// commands never overlap
	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accum, cmd.load, cmd.div_step, cmd.commit}))
		else $error("overlapping datapath commands");

endmodule

/* tb/tb_region_mean_colour_change_detect.sv */
// ----------------------------------------------------------------------------
// tb_region_mean_colour_change_detect
// Self-checking bench for the region mean colour change detector.
// ----------------------------------------------------------------------------
// Pixel words are pushed into a queue by the stimulus process and sent by a
// clocked driver with random gaps. Each accepted pixel word feeds a local
// predictor, which keeps its own sums, count, last sent colour and threshold,
// and queues the mean colour words the block should send. A clocked monitor
// takes mean words with random stalls and compares them field by field with
// the oldest queued mean. The threshold is changed over APB between phases,
// only once the block has gone quiet, and is read back after every write.
// ----------------------------------------------------------------------------
module tb_region_mean_colour_change_detect;
	import rmc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned PIXEL_CAP    = DEF_MAX_PIXELS;
	localparam int          DRAIN_CYCLES = 32;
	localparam int          CYCLE_LIMIT  = 200_000;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} pixel_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} colour_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	rmc_pix_if  pix_bus ();
	rmc_mean_if mean_bus ();

	region_mean_colour_change_detect #(
		.MAX_PIXELS(PIXEL_CAP)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix_bus),
		.mean   (mean_bus),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	// pending pixel words and mean words still owed by the block
	pixel_t  pixel_q[$];
	colour_t mean_q[$];

	// predictor state
	logic [19:0]      red_acc;
	logic [19:0]      green_acc;
	logic [19:0]      blue_acc;
	logic [12:0]      tally;
	colour_t          shown;
	logic             shown_valid;
	logic [THR_W-1:0] thr_shadow;

	// idling: percent of words that draw a random idle wait
	int tx_idle_pct;
	int rx_idle_pct;
	int tx_wait;
	int rx_wait;

	int      mismatches;
	int      pixels_taken;
	int      frames_taken;
	int      means_seen;
	int      cycles;
	colour_t base;

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL region_mean_colour_change_detect");
			$finish;
		end
	end

	function automatic int draw_wait(input int pct);
		if ($urandom_range(1, 100) <= pct)
			return $urandom_range(0, 16);
		return 0;
	endfunction

	function automatic int chan_gap(input logic [7:0] a, input logic [7:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	// expected behavior for one accepted pixel word
	function automatic void take_pixel(input pixel_t p);
		colour_t avg;
		int      diff;
		pixels_taken++;
		// sums hold once the pixel cap is reached
		if (tally < PIXEL_CAP) begin
			red_acc   += p.red;
			green_acc += p.green;
			blue_acc  += p.blue;
			tally     += 1;
		end
		if (!p.last)
			return;
		frames_taken++;
		avg.red   = (tally == 0) ? 8'd0 : 8'(red_acc / tally);
		avg.green = (tally == 0) ? 8'd0 : 8'(green_acc / tally);
		avg.blue  = (tally == 0) ? 8'd0 : 8'(blue_acc / tally);
		red_acc   = '0;
		green_acc = '0;
		blue_acc  = '0;
		tally     = '0;
		diff = chan_gap(avg.red, shown.red) + chan_gap(avg.green, shown.green)
			+ chan_gap(avg.blue, shown.blue);
		// first colour always goes out, later ones only on a real change
		if (shown_valid && diff <= thr_shadow)
			return;
		shown       = avg;
		shown_valid = 1'b1;
		mean_q.push_back(avg);
	endfunction

	function automatic void check_chan(input string chan, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, chan, want, got);
		end
	endfunction

	// pixel driver
	always @(posedge clk or negedge arst_n) begin : pixel_driver
		pixel_t nxt;
		if (!arst_n) begin
			pix_bus.valid <= 1'b0;
			tx_wait <= 0;
		end else begin
			if (pix_bus.valid && pix_bus.ready)
				take_pixel({pix_bus.pixel_red, pix_bus.pixel_green, pix_bus.pixel_blue,
					pix_bus.last_pixel});
			if (!pix_bus.valid || pix_bus.ready) begin
				if (tx_wait > 0) begin
					pix_bus.valid <= 1'b0;
					tx_wait <= tx_wait - 1;
				end else if (pixel_q.size() > 0) begin
					nxt = pixel_q.pop_front();
					pix_bus.pixel_red   <= nxt.red;
					pix_bus.pixel_green <= nxt.green;
					pix_bus.pixel_blue  <= nxt.blue;
					pix_bus.last_pixel  <= nxt.last;
					pix_bus.valid       <= 1'b1;
					tx_wait <= draw_wait(tx_idle_pct);
				end else begin
					pix_bus.valid <= 1'b0;
				end
			end
		end
	end

	// mean word monitor and ready stalls
	always @(posedge clk or negedge arst_n) begin : mean_monitor
		colour_t want;
		int      hold;
		if (!arst_n) begin
			mean_bus.ready <= 1'b0;
			rx_wait <= 0;
		end else begin
			hold = rx_wait;
			if (mean_bus.valid && mean_bus.ready) begin
				means_seen++;
				if (mean_q.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected mean word: expected none, actual %0d/%0d/%0d",
						$time, mean_bus.mean_red, mean_bus.mean_green, mean_bus.mean_blue);
				end else begin
					want = mean_q.pop_front();
					check_chan("mean_red", want.red, mean_bus.mean_red);
					check_chan("mean_green", want.green, mean_bus.mean_green);
					check_chan("mean_blue", want.blue, mean_bus.mean_blue);
				end
				hold = draw_wait(rx_idle_pct);
			end
			if (hold > 0) begin
				mean_bus.ready <= 1'b0;
				rx_wait <= hold - 1;
			end else begin
				mean_bus.ready <= 1'b1;
				rx_wait <= 0;
			end
		end
	end

	// one APB transfer to the threshold register; ends on a falling edge
	task automatic apb_access(input logic wr, input logic [APB_DW-1:0] wdata,
		output logic [APB_DW-1:0] rdata);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= ADDR_THRESH;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic check_threshold();
		logic [APB_DW-1:0] rd;
		apb_access(1'b0, '0, rd);
		if (rd[THR_W-1:0] !== thr_shadow) begin
			mismatches++;
			$display("%0t: threshold readback mismatch: expected %0d, actual %0d",
				$time, thr_shadow, rd[THR_W-1:0]);
		end
	endtask

	task automatic set_threshold(input logic [APB_DW-1:0] value);
		logic [APB_DW-1:0] rd;
		apb_access(1'b1, value, rd);
		thr_shadow = value[THR_W-1:0];
		check_threshold();
	endtask

	task automatic push_px(input int r, input int g, input int b, input bit last);
		pixel_q.push_back({8'(r), 8'(g), 8'(b), last});
	endtask

	function automatic logic [7:0] near(input logic [7:0] c, input int span);
		int v;
		v = int'(c) + $urandom_range(0, 2 * span) - span;
		return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
	endfunction

	// random frames: a drifting base colour with jitter, some raw pixels
	task automatic add_frames(input int budget);
		int     left;
		int     len;
		pixel_t p;
		left = budget;
		while (left > 0) begin
			if ($urandom_range(0, 3) == 0)
				base = colour_t'($urandom());
			else
				base = {near(base.red, 3), near(base.green, 3), near(base.blue, 3)};
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 7) == 0)
					p = pixel_t'($urandom());
				else
					p = {near(base.red, 2), near(base.green, 2), near(base.blue, 2), 1'b0};
				p.last = (i == len - 1);
				pixel_q.push_back(p);
			end
			left -= len;
		end
	endtask

	// wait for the block to go quiet; frames that send nothing still take time
	task automatic drain();
		@(negedge clk);
		while (pixel_q.size() != 0 || pix_bus.valid || mean_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// stimulus
	initial begin
		arst_n = 1'b0;
		pix_bus.valid = 1'b0;
		pix_bus.pixel_red = '0;
		pix_bus.pixel_green = '0;
		pix_bus.pixel_blue = '0;
		pix_bus.last_pixel = 1'b0;
		mean_bus.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		red_acc = '0;
		green_acc = '0;
		blue_acc = '0;
		tally = '0;
		shown = '0;
		shown_valid = 1'b0;
		thr_shadow = THRESH_RST;
		tx_idle_pct = 100;
		rx_idle_pct = 100;
		mismatches = 0;
		pixels_taken = 0;
		frames_taken = 0;
		means_seen = 0;
		cycles = 0;
		base = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		check_threshold();

		// reset threshold: first colour, full swing, differences around 3
		push_px(0, 0, 0, 1);
		push_px(255, 255, 255, 1);
		push_px(255, 255, 253, 1);
		push_px(255, 254, 253, 1);
		push_px(254, 254, 253, 1);
		push_px(255, 0, 170, 0);
		push_px(0, 255, 85, 1);
		push_px(1, 2, 3, 0);
		push_px(0, 0, 0, 0);
		push_px(0, 0, 1, 1);
		push_px(8'hAA, 8'h55, 8'hF0, 0);
		push_px(8'h55, 8'hAA, 8'h0F, 1);
		add_frames(200);
		drain();

		// zero threshold: any change at all goes out
		set_threshold(32'd0);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		push_px(9, 9, 9, 1);
		push_px(9, 9, 9, 1);
		push_px(9, 9, 10, 1);
		add_frames(150);
		drain();

		// top of range: nothing can exceed it
		set_threshold(32'd765);
		tx_idle_pct = 50;
		rx_idle_pct = 50;
		push_px(0, 0, 0, 1);
		push_px(255, 255, 255, 1);
		add_frames(100);
		drain();

		// all data bits set; only the low bits land in the register
		set_threshold('1);
		tx_idle_pct = 100;
		rx_idle_pct = 0;
		add_frames(60);
		drain();

		// random thresholds with mixed idling
		for (int k = 0; k < 3; k++) begin
			set_threshold((k == 2) ? $urandom_range(41, 764) : $urandom_range(1, 40));
			tx_idle_pct = 50 * k;
			rx_idle_pct = 100 - 50 * k;
			add_frames(120);
			drain();
		end

		set_threshold(32'(THRESH_RST));
		tx_idle_pct = 100;
		rx_idle_pct = 100;
		add_frames(60);
		drain();

		$display("Sent %0d pixel words in %0d frames of one to 64 pixels;",
			pixels_taken, frames_taken);
		$display("checked %0d mean words over thresholds 0, 3, 765, 1023 and random values.",
			means_seen);
		if (mismatches == 0)
			$display("PASS region_mean_colour_change_detect");
		else
			$display("FAIL region_mean_colour_change_detect");
		$finish;
	end

endmodule
